### rtl/erc_pkg.sv
package erc_pkg;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // configuration register indexes
  localparam logic [1:0] CFG_ESCAPE  = 2'd0;
  localparam logic [1:0] CFG_MIN_RUN = 2'd1;
  localparam logic [1:0] CFG_MAX_RUN = 2'd2;
  localparam logic [1:0] CFG_LIMIT   = 2'd3;

  localparam logic [3:0]  MIN_RUN_LO  = 4'd4;
  localparam logic [3:0]  MIN_RUN_HI  = 4'd8;
  localparam logic [8:0]  MAX_RUN_LO  = 9'd4;
  localparam logic [8:0]  MAX_RUN_HI  = 9'd258;
  localparam logic [8:0]  RUN_BIAS    = 9'd3;
  localparam logic [7:0]  ESC_LITERAL = 8'h00;

  localparam logic [1:0] TOK_LEN_LIT = 2'd1;
  localparam logic [1:0] TOK_LEN_ESC = 2'd2;
  localparam logic [1:0] TOK_LEN_RUN = 2'd3;

  typedef struct packed {
    logic [7:0]  escape_code;
    logic [3:0]  min_run;
    logic [8:0]  max_run;
    logic [31:0] out_limit;
  } erc_cfg_t;

  // one job per item that closes a run: the old run (a) and/or the final run (b)
  typedef struct packed {
    logic       flush_a;
    logic [8:0] len_a;
    logic [7:0] val_a;
    logic       eos;
    logic [8:0] len_b;
    logic [7:0] val_b;
  } erc_job_t;

endpackage

### rtl/erc_front.sv
module erc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               end_of_source,
  input  logic [8:0]         max_run,
  input  logic               q_full,
  output logic               q_push,
  output erc_pkg::erc_job_t  q_job
);
  import erc_pkg::*;

  logic [7:0] run_val_r, run_val_nxt;
  logic [8:0] run_len_r, run_len_nxt;
  logic       accept;
  logic       flush_a;
  logic [8:0] len_b;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    flush_a = (run_len_r != 9'd0) && ((data_byte != run_val_r) || (run_len_r >= max_run));
    len_b   = flush_a ? 9'd1 : run_len_r + 9'd1;

    q_job.flush_a = flush_a;
    q_job.len_a   = run_len_r;
    q_job.val_a   = run_val_r;
    q_job.eos     = end_of_source;
    q_job.len_b   = len_b;
    q_job.val_b   = data_byte;

    // an item that only extends a run produces no job
    q_push = accept && (flush_a || end_of_source);

    run_val_nxt = run_val_r;
    run_len_nxt = run_len_r;
    if (accept) begin
      run_val_nxt = data_byte;
      run_len_nxt = end_of_source ? 9'd0 : len_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_val_r <= 8'd0;
      run_len_r <= 9'd0;
    end else begin
      run_val_r <= run_val_nxt;
      run_len_r <= run_len_nxt;
    end
  end

endmodule

### rtl/erc_queue.sv
module erc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  erc_pkg::erc_job_t  push_job,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output erc_pkg::erc_job_t  head_job
);
  import erc_pkg::*;

  erc_job_t           ent_r [Q_DEPTH];
  logic [Q_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]    cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full       = (cnt_r == Q_CW'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = ent_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CW'(Q_DEPTH))
    else $error("job queue count past depth");

endmodule

### rtl/erc_back.sv
module erc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  erc_pkg::erc_cfg_t  cfg,
  input  logic               job_valid,
  input  erc_pkg::erc_job_t  job,
  output logic               job_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               burst_last,
  output logic               stream_done,
  output logic               overflow
);
  import erc_pkg::*;

  logic        phase_r, phase_nxt;
  logic [1:0]  bidx_r, bidx_nxt;
  logic [2:0]  lit_cnt_r, lit_cnt_nxt;
  logic [31:0] written_r, written_nxt;
  logic        failed_r, failed_nxt;

  logic        ov_valid_r, ov_valid_nxt;
  logic [7:0]  ov_byte_r, ov_byte_nxt;
  logic        ov_last_r, ov_last_nxt;
  logic        ov_done_r, ov_done_nxt;
  logic        ov_ovf_r, ov_ovf_nxt;

  logic        can_emit;
  logic        go;
  logic        cur_active;
  logic [8:0]  cur_len;
  logic [7:0]  cur_val;
  logic        is_run;
  logic        lit_esc;
  logic [1:0]  tok_len;
  logic [32:0] sum;
  logic        over;
  logic [7:0]  tok_byte;
  logic [8:0]  len_m3;
  logic        tok_end;
  logic        lit_last;
  logic        phase_end;
  logic        entry_end;
  logic        emit_byte;

  assign can_emit = !ov_valid_r || out_ready;
  assign go       = job_valid && can_emit;

  always_comb begin
    cur_active = phase_r ? job.eos   : job.flush_a;
    cur_len    = phase_r ? job.len_b : job.len_a;
    cur_val    = phase_r ? job.val_b : job.val_a;
    is_run     = cur_len >= {5'd0, cfg.min_run};
    lit_esc    = cur_val == cfg.escape_code;
    tok_len    = is_run ? TOK_LEN_RUN : (lit_esc ? TOK_LEN_ESC : TOK_LEN_LIT);
    sum        = {1'b0, written_r} + {31'd0, tok_len};
    // check the whole token against the limit before its first byte
    over       = (bidx_r == 2'd0) && (sum > {1'b0, cfg.out_limit});
    len_m3     = cur_len - RUN_BIAS;

    tok_byte = cur_val;
    if (is_run) begin
      case (bidx_r)
        2'd0:    tok_byte = cfg.escape_code;
        2'd1:    tok_byte = len_m3[7:0];
        default: tok_byte = cur_val;
      endcase
    end else if (lit_esc) begin
      tok_byte = (bidx_r == 2'd0) ? cfg.escape_code : ESC_LITERAL;
    end

    tok_end   = bidx_r == (tok_len - 2'd1);
    lit_last  = ({6'd0, lit_cnt_r} + 9'd1) == cur_len;
    phase_end = tok_end && (is_run || lit_last);
    entry_end = phase_end && (phase_r || !job.eos);

    phase_nxt    = phase_r;
    bidx_nxt     = bidx_r;
    lit_cnt_nxt  = lit_cnt_r;
    written_nxt  = written_r;
    failed_nxt   = failed_r;
    job_pop      = 1'b0;
    emit_byte    = 1'b0;

    ov_valid_nxt = ov_valid_r && !out_ready;
    ov_byte_nxt  = ov_byte_r;
    ov_last_nxt  = ov_last_r;
    ov_done_nxt  = ov_done_r;
    ov_ovf_nxt   = ov_ovf_r;

    if (go) begin
      if (failed_r) begin
        // drop the rest of a failed stream; its end mark starts a fresh one
        job_pop = 1'b1;
        if (job.eos) begin
          failed_nxt  = 1'b0;
          written_nxt = 32'd0;
        end
      end else if (!cur_active) begin
        if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          job_pop   = 1'b1;
          phase_nxt = 1'b0;
        end
      end else if (over) begin
        ov_valid_nxt = 1'b1;
        ov_byte_nxt  = 8'd0;
        ov_last_nxt  = 1'b1;
        ov_done_nxt  = 1'b1;
        ov_ovf_nxt   = 1'b1;
        job_pop      = 1'b1;
        phase_nxt    = 1'b0;
        bidx_nxt     = 2'd0;
        lit_cnt_nxt  = 3'd0;
        if (job.eos) begin
          written_nxt = 32'd0;
        end else begin
          failed_nxt = 1'b1;
        end
      end else begin
        emit_byte    = 1'b1;
        ov_valid_nxt = 1'b1;
        ov_byte_nxt  = tok_byte;
        ov_last_nxt  = entry_end;
        ov_done_nxt  = entry_end && job.eos;
        ov_ovf_nxt   = 1'b0;
        if (bidx_r == 2'd0) begin
          written_nxt = sum[31:0];
        end
        if (!tok_end) begin
          bidx_nxt = bidx_r + 2'd1;
        end else begin
          bidx_nxt    = 2'd0;
          lit_cnt_nxt = lit_cnt_r + 3'd1;
        end
        if (phase_end) begin
          lit_cnt_nxt = 3'd0;
          if (entry_end) begin
            job_pop   = 1'b1;
            phase_nxt = 1'b0;
            if (job.eos) begin
              written_nxt = 32'd0;
            end
          end else begin
            phase_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= 1'b0;
      bidx_r     <= 2'd0;
      lit_cnt_r  <= 3'd0;
      written_r  <= 32'd0;
      failed_r   <= 1'b0;
      ov_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      bidx_r     <= bidx_nxt;
      lit_cnt_r  <= lit_cnt_nxt;
      written_r  <= written_nxt;
      failed_r   <= failed_nxt;
      ov_valid_r <= ov_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ov_byte_r <= ov_byte_nxt;
    ov_last_r <= ov_last_nxt;
    ov_done_r <= ov_done_nxt;
    ov_ovf_r  <= ov_ovf_nxt;
  end

  assign out_valid   = ov_valid_r;
  assign out_byte    = ov_byte_r;
  assign burst_last  = ov_last_r;
  assign stream_done = ov_done_r;
  assign overflow    = ov_ovf_r;

  a_ovf_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_valid_r && ov_ovf_r) |-> (ov_last_r && ov_done_r && ov_byte_r == 8'd0))
    else $error("overflow result must close the stream");

  a_failed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> !emit_byte)
    else $error("byte emitted after overflow");

  a_bidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    bidx_r != 2'd3)
    else $error("token byte index out of range");

  a_failed_idle: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> (phase_r == 1'b0 && bidx_r == 2'd0 && lit_cnt_r == 3'd0))
    else $error("sequencer busy while stream failed");

endmodule

### rtl/escape_rle_compressor.sv
// Escape-byte run-length compressor. Source bytes enter on in_* (in_tlast marks the last
// byte of a stream); compressed bytes leave on out_* with out_tlast on the last byte caused
// by one input item, out_tuser[0] on the last byte of a stream and out_tuser[1] on the single
// overflow result that ends a failed stream. The front takes one item per cycle while its
// two-entry job queue has room; an item that only extends a run produces no job. The back
// emits one result per cycle through its output register while a job waits and the receiver
// is ready, plus an idle step when an end-of-stream item has no earlier run to close; a job
// dropped after overflow is popped with no output. An item that closes a run yields 1 to 16
// bytes: three for a run token, one per literal, two per escaped literal. Write
// configuration only when the block is idle; min_run and max_run are clamped to their legal
// ranges on write. No clearing pass follows reset.
module escape_rle_compressor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,
  output logic [1:0]  out_tuser,  // [0] stream_done, [1] overflow
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import erc_pkg::*;

  erc_cfg_t   cfg_r, cfg_nxt;
  erc_job_t   push_job;
  erc_job_t   head_job;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  logic       done;
  logic       ovf;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ESCAPE: cfg_nxt.escape_code = cfg_wdata[7:0];
        CFG_MIN_RUN: begin
          if (cfg_wdata[3:0] < MIN_RUN_LO) begin
            cfg_nxt.min_run = MIN_RUN_LO;
          end else if (cfg_wdata[3:0] > MIN_RUN_HI) begin
            cfg_nxt.min_run = MIN_RUN_HI;
          end else begin
            cfg_nxt.min_run = cfg_wdata[3:0];
          end
        end
        CFG_MAX_RUN: begin
          if (cfg_wdata[8:0] < MAX_RUN_LO) begin
            cfg_nxt.max_run = MAX_RUN_LO;
          end else if (cfg_wdata[8:0] > MAX_RUN_HI) begin
            cfg_nxt.max_run = MAX_RUN_HI;
          end else begin
            cfg_nxt.max_run = cfg_wdata[8:0];
          end
        end
        CFG_LIMIT: cfg_nxt.out_limit = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.escape_code <= 8'hFF;
      cfg_r.min_run     <= MIN_RUN_LO;
      cfg_r.max_run     <= MAX_RUN_HI;
      cfg_r.out_limit   <= 32'hFFFF_FFFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  erc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .data_byte     (in_tdata),
    .end_of_source (in_tlast),
    .max_run       (cfg_r.max_run),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  erc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  erc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .job_valid   (q_valid),
    .job         (head_job),
    .job_pop     (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_byte    (out_tdata),
    .burst_last  (out_tlast),
    .stream_done (done),
    .overflow    (ovf)
  );

  assign out_tuser = {ovf, done};

endmodule

### tb/erc_checker.sv
module erc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] out_byte
  input  logic        out_tlast,
  input  logic [1:0]  out_tuser,  // [0] stream_done, [1] overflow
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          pending,
  output int          errors,
  output int          results_seen,
  output int          overflows_seen
);
  import erc_pkg::*;

  localparam int MAX_BURST = 16;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       burst_last;
    logic       stream_done;
    logic       overflow;
  } erc_result_t;

  // register copies
  logic [7:0]  esc_code;
  logic [3:0]  min_len;
  logic [8:0]  max_len;
  logic [31:0] byte_limit;

  // compressor state
  logic [7:0]  run_byte;
  logic [8:0]  run_len;
  logic [31:0] bytes_out;
  logic        stream_failed;

  erc_result_t burst[$];
  erc_result_t expected_bytes[$];

  function automatic void add_result(input logic [7:0] value, input logic ovf);
    erc_result_t r;
    if (burst.size() >= MAX_BURST) return;
    r.out_byte    = ovf ? 8'h00 : value;
    r.burst_last  = 1'b0;
    r.stream_done = 1'b0;
    r.overflow    = ovf;
    burst.push_back(r);
  endfunction

  // whole token or a single overflow marker, never part of a token
  function automatic void emit_token(input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2, input logic [1:0] len);
    logic [32:0] total;
    if (stream_failed) return;
    total = {1'b0, bytes_out} + 33'(len);
    if (total > {1'b0, byte_limit}) begin
      stream_failed = 1'b1;
      run_len = '0;
      add_result(8'h00, 1'b1);
      return;
    end
    add_result(b0, 1'b0);
    if (len > TOK_LEN_LIT) add_result(b1, 1'b0);
    if (len > TOK_LEN_ESC) add_result(b2, 1'b0);
    bytes_out = bytes_out + 32'(len);
  endfunction

  function automatic void flush_run();
    logic [8:0] len;
    len = run_len;
    if (len == 0 || stream_failed) return;
    run_len = '0;
    if (len >= 9'(min_len)) begin
      emit_token(esc_code, 8'(len - RUN_BIAS), run_byte, TOK_LEN_RUN);
    end else begin
      for (int i = 0; i < len && !stream_failed; i++) begin
        if (run_byte == esc_code) begin
          emit_token(esc_code, ESC_LITERAL, 8'h00, TOK_LEN_ESC);
        end else begin
          emit_token(run_byte, 8'h00, 8'h00, TOK_LEN_LIT);
        end
      end
    end
  endfunction

  function automatic void compress_item(input logic [7:0] d, input logic eos);
    logic        was_failed;
    erc_result_t r;
    was_failed = stream_failed;
    burst.delete();
    if (!stream_failed) begin
      if (run_len != 0 && (d != run_byte || run_len >= max_len)) flush_run();
      if (!stream_failed) begin
        run_byte = d;
        run_len  = run_len + 9'd1;
      end
      if (eos && !stream_failed) flush_run();
    end
    if (burst.size() > 0) begin
      r = burst.pop_back();
      r.burst_last = 1'b1;
      if (eos || (stream_failed && !was_failed)) r.stream_done = 1'b1;
      burst.push_back(r);
    end
    foreach (burst[i]) expected_bytes.push_back(burst[i]);
    if (eos) begin
      run_len       = '0;
      bytes_out     = '0;
      stream_failed = 1'b0;
    end
  endfunction

  function automatic void write_register(input logic [1:0] idx, input logic [31:0] data);
    case (idx)
      CFG_ESCAPE: esc_code = data[7:0];
      CFG_MIN_RUN: begin
        if (data[3:0] < MIN_RUN_LO) min_len = MIN_RUN_LO;
        else if (data[3:0] > MIN_RUN_HI) min_len = MIN_RUN_HI;
        else min_len = data[3:0];
      end
      CFG_MAX_RUN: begin
        if (data[8:0] < MAX_RUN_LO) max_len = MAX_RUN_LO;
        else if (data[8:0] > MAX_RUN_HI) max_len = MAX_RUN_HI;
        else max_len = data[8:0];
      end
      CFG_LIMIT: byte_limit = data;
      default: ;
    endcase
  endfunction

  function automatic void check_result();
    erc_result_t want;
    results_seen++;
    if (expected_bytes.size() == 0) begin
      $error("unexpected result: out_byte %0h, tlast %0b, tuser %0b",
             out_tdata, out_tlast, out_tuser);
      errors++;
      return;
    end
    want = expected_bytes.pop_front();
    if (want.overflow) overflows_seen++;
    if (out_tdata !== want.out_byte) begin
      $error("out_byte: expected %0h, got %0h", want.out_byte, out_tdata);
      errors++;
    end
    if (out_tlast !== want.burst_last) begin
      $error("burst_last: expected %0b, got %0b", want.burst_last, out_tlast);
      errors++;
    end
    if (out_tuser[0] !== want.stream_done) begin
      $error("stream_done: expected %0b, got %0b", want.stream_done, out_tuser[0]);
      errors++;
    end
    if (out_tuser[1] !== want.overflow) begin
      $error("overflow: expected %0b, got %0b", want.overflow, out_tuser[1]);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      esc_code      = 8'hFF;
      min_len       = MIN_RUN_LO;
      max_len       = MAX_RUN_HI;
      byte_limit    = '1;
      run_byte      = '0;
      run_len       = '0;
      bytes_out     = '0;
      stream_failed = 1'b0;
      expected_bytes.delete();
    end else begin
      if (cfg_we) write_register(cfg_index, cfg_wdata);
      // push before pop so a same-edge result still finds its expectation
      if (in_tvalid && in_tready) compress_item(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_result();
    end
    pending = expected_bytes.size();
  end

endmodule

### tb/tb_top.sv
module tb_top;
  import erc_pkg::*;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tready = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = CFG_ESCAPE;
  logic [31:0] cfg_wdata  = 32'h0;

  logic        in_tready;
  logic        out_tvalid;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;

  int pending;
  int errors;
  int results_seen;
  int overflows_seen;

  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_left  = 0;
  int items_sent = 0;
  int phase_start;

  // stimulus view of the current settings
  logic [7:0] esc_now = 8'hFF;
  int         min_now = 4;
  int         max_now = 258;

  escape_rle_compressor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  erc_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .pending        (pending),
    .errors         (errors),
    .results_seen   (results_seen),
    .overflows_seen (overflows_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("** escape_rle_compressor: FAILED **");
    $finish;
  end

  // receiver: long hold-off when requested, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(input logic [7:0] d, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = d;
    in_tlast  = last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
    items_sent++;
  endtask

  task automatic send_run(input logic [7:0] v, input int len, input logic last);
    for (int i = 0; i < len; i++) send_item(v, last && (i == len - 1));
  endtask

  // wait for all results, then let any dropped items clear the pipeline
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input logic [7:0] esc, input logic [31:0] min_w,
                           input logic [31:0] max_w, input logic [31:0] limit);
    write_reg(CFG_ESCAPE, {24'h0, esc});
    write_reg(CFG_MIN_RUN, min_w);
    write_reg(CFG_MAX_RUN, max_w);
    write_reg(CFG_LIMIT, limit);
    esc_now = esc;
    min_now = (min_w[3:0] < 4) ? 4 : ((min_w[3:0] > 8) ? 8 : int'(min_w[3:0]));
    max_now = (max_w[8:0] < 4) ? 4 : ((max_w[8:0] > 258) ? 258 : int'(max_w[8:0]));
  endtask

  // mostly runs of chosen lengths, some plain noise; tlast on the final item
  task automatic random_stream();
    int         runs;
    int         len;
    int         r;
    logic [7:0] v;
    logic [7:0] prev;
    prev = 8'($urandom);
    if ($urandom_range(99) < 15) begin
      len = $urandom_range(12, 1);
      for (int i = 0; i < len; i++) send_item(8'($urandom), i == len - 1);
    end else begin
      runs = $urandom_range(6, 1);
      for (int k = 0; k < runs; k++) begin
        case ($urandom_range(3, 0))
          0:       v = esc_now;
          1:       v = prev;
          default: v = 8'($urandom);
        endcase
        r = $urandom_range(9, 0);
        if (r < 6) len = $urandom_range(min_now + 1, 1);
        else if (r < 9) len = $urandom_range(min_now + 3, min_now);
        else if (max_now <= 40) len = max_now + $urandom_range(3, 1);
        else len = $urandom_range(3, 1);
        send_run(v, len, k == runs - 1);
        prev = v;
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // plain literal, escaped literal, shortest run token, escaped short run
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_run(8'hAA, 4, 1'b1);
    send_run(8'hFF, 3, 1'b1);
    send_run(8'h55, 2, 1'b0);
    send_item(8'hFF, 1'b1);
    drain();

    // clamped settings: runs split at max_run and sent as escaped literals
    configure(8'h00, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_run(8'h00, 9, 1'b1);
    drain();

    // overflow on the third token, rest of the stream dropped
    configure(8'hFF, 32'h0, 32'd258, 32'd2);
    send_item(8'h11, 1'b0);
    send_item(8'h22, 1'b0);
    send_item(8'h33, 1'b0);
    send_item(8'h44, 1'b1);

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: configure(8'hFF, 32'd4, 32'd258, 32'hFFFF_FFFF);
        1: configure(8'h00, 32'd8, 32'd4, 32'hFFFF_FFFF);
        2: configure(8'($urandom), 32'd5, 32'd9, $urandom_range(60, 20));
        3: configure(8'h80, 32'd6, 32'd511, 32'd0);
        4: configure(8'h7F, 32'd0, 32'd12, 32'hFFFF_FFFF);
        default: configure(8'($urandom), $urandom_range(8, 4), $urandom_range(40, 4),
                           $urandom_range(1, 0) ? 32'hFFFF_FFFF : $urandom_range(120, 8));
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      // one long run sent as a single token
      if (p == 0) send_run(8'h3C, 12, 1'b1);
      if (p == 2) begin
        // hold the receiver while literal-heavy data backs up the block
        hold_left = 300;
        for (int i = 0; i < 30; i++) send_item((i % 2 == 0) ? esc_now : 8'(i * 7), i == 29);
      end
      phase_start = items_sent;
      while (items_sent - phase_start < 10) random_stream();
    end

    drain();
    $display("Covered %0d source items, %0d compressed results (%0d overflow markers),",
             items_sent, results_seen, overflows_seen);
    $display("across eight register settings and four sender/receiver idling mixes.");
    if (errors == 0 && pending == 0) begin
      $display("** escape_rle_compressor: PASSED **");
    end else begin
      $display("** escape_rle_compressor: FAILED **");
    end
    $finish;
  end

endmodule
